/* hdl/tspea_pkg.sv */
`default_nettype none

package tspea_pkg;

	localparam int STAMP_W   = 64;
	localparam int LIM_W     = 20;
	localparam int WIN_W     = 16;
	localparam int SUM_W     = 38;
	localparam int MEAN_W    = 37;
	localparam int FRAC_W    = 16;
	// The magnitude of the sum stays below 2^36, so 36 integer bits plus fraction.
	localparam int SUMMAG_W  = 36;
	localparam int DVD_W     = SUMMAG_W + FRAC_W;
	localparam int DIV_STEPS = DVD_W;
	localparam int ITER_W    = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_CLIP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REJECT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd2;

	localparam logic [LIM_W-1:0] CLIP_RESET   = 20'd1000;
	localparam logic [LIM_W-1:0] REJECT_RESET = 20'd10000;
	localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd1;

	typedef struct packed {
		logic [LIM_W-1:0] clip_limit;
		logic [LIM_W-1:0] reject_limit;
		logic [WIN_W-1:0] window_eff;
	} cfg_t;

	typedef struct packed {
		logic load_in;
		logic calc_diff;
		logic prime;
		logic calc_delta;
		logic calc_mag;
		logic accum;
		logic div_init;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic primed;
		logic reject;
		logic emit;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

/* hdl/tspea_regs.sv */
`default_nettype none

module tspea_regs import tspea_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_DAT_W-1:0] wr_data,
	output cfg_t                      cfg
);

	logic [LIM_W-1:0] clip_q;
	logic [LIM_W-1:0] reject_q;
	logic [WIN_W-1:0] window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q   <= CLIP_RESET;
			reject_q <= REJECT_RESET;
			window_q <= WINDOW_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_CLIP:   clip_q   <= wr_data[LIM_W-1:0];
				CFG_REJECT: reject_q <= wr_data[LIM_W-1:0];
				CFG_WINDOW: window_q <= wr_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// A window length of zero behaves as one.
	always_comb begin
		cfg.clip_limit   = clip_q;
		cfg.reject_limit = reject_q;
		cfg.window_eff   = (window_q == '0) ? WIN_W'(1) : window_q;
	end

endmodule

`default_nettype wire

/* hdl/tspea_ctrl.sv */
`default_nettype none

module tspea_ctrl import tspea_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire status_t status,
	output cmd_t      cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIFF  = 3'd1;
	localparam logic [2:0] S_DELTA = 3'd2;
	localparam logic [2:0] S_MAG   = 3'd3;
	localparam logic [2:0] S_ACC   = 3'd4;
	localparam logic [2:0] S_DSET  = 3'd5;
	localparam logic [2:0] S_DIV   = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	logic [2:0]        state_q;
	logic [2:0]        state_nxt;
	logic [ITER_W-1:0] iter_q;
	logic              last_step;

	assign last_step = (iter_q == ITER_W'(DIV_STEPS - 1));
	assign in_stall  = (state_q != S_IDLE);

	always_comb begin
		cmd        = '0;
		state_nxt  = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid) state_nxt = S_DIFF;
			end
			S_DIFF: begin
				cmd.calc_diff = 1'b1;
				state_nxt     = S_DELTA;
			end
			S_DELTA: begin
				if (!status.primed) begin
					cmd.prime = 1'b1;
					state_nxt = S_IDLE;
				end else begin
					cmd.calc_delta = 1'b1;
					state_nxt      = S_MAG;
				end
			end
			S_MAG: begin
				cmd.calc_mag = 1'b1;
				state_nxt    = S_ACC;
			end
			S_ACC: begin
				if (status.reject) begin
					state_nxt = S_IDLE;
				end else begin
					cmd.accum = 1'b1;
					state_nxt = status.emit ? S_DSET : S_IDLE;
				end
			end
			S_DSET: begin
				cmd.div_init = 1'b1;
				state_nxt    = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (last_step) state_nxt = S_OUT;
			end
			S_OUT: begin
				// Hold the quotient until the output register can take it.
				cmd.out_load = status.out_free;
				if (status.out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.div_init) begin
				iter_q <= '0;
			end else if (cmd.div_step) begin
				iter_q <= iter_q + ITER_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/tspea_dp.sv */
`default_nettype none

module tspea_dp import tspea_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [STAMP_W-1:0]       ref_stamp,
	input  wire logic [STAMP_W-1:0]       sig_stamp,
	input  wire cfg_t                     cfg,
	input  wire cmd_t                     cmd,
	output status_t                       status,
	input  wire logic                     out_stall,
	output logic                          out_valid,
	output logic signed [MEAN_W-1:0]      mean_delta
);

	logic [STAMP_W-1:0] ref_q;
	logic [STAMP_W-1:0] sig_q;
	logic [STAMP_W-1:0] diff_q;
	logic [STAMP_W-1:0] last_q;
	logic [STAMP_W-1:0] delta_q;
	logic [STAMP_W-1:0] mag_q;
	logic               neg_q;

	logic               primed_q;
	logic [SUM_W-1:0]   sum_q;
	logic [WIN_W-1:0]   cnt_q;

	logic [WIN_W-1:0]   rem_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [WIN_W-1:0]   divisor_q;
	logic               dneg_q;

	logic [MEAN_W-1:0]  mean_q;
	logic               out_valid_q;

	logic [WIN_W-1:0]   cnt_inc;
	logic [LIM_W-1:0]   clip_mag;
	logic [SUM_W-1:0]   addend;
	logic [SUM_W-1:0]   sum_abs;
	logic [WIN_W:0]     trial;
	logic               trial_ge;
	logic [MEAN_W-1:0]  quot;

	assign cnt_inc  = cnt_q + WIN_W'(1);
	assign clip_mag = (mag_q < STAMP_W'(cfg.clip_limit)) ? mag_q[LIM_W-1:0] : cfg.clip_limit;
	assign addend   = neg_q ? (SUM_W'(0) - SUM_W'(clip_mag)) : SUM_W'(clip_mag);
	assign sum_abs  = sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;
	assign trial    = {rem_q, dvd_q[DVD_W-1]};
	assign trial_ge = (trial >= {1'b0, divisor_q});
	assign quot     = dvd_q[MEAN_W-1:0];

	always_comb begin
		status.primed   = primed_q;
		status.reject   = (mag_q >= STAMP_W'(cfg.reject_limit));
		status.emit     = (cnt_inc >= cfg.window_eff);
		status.out_free = !out_valid_q || !out_stall;
	end

	// Front end: difference, delta and its magnitude, one step a cycle.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ref_q <= ref_stamp;
			sig_q <= sig_stamp;
		end
		if (cmd.calc_diff) diff_q <= sig_q - ref_q;
		if (cmd.prime || cmd.calc_delta) last_q <= diff_q;
		if (cmd.calc_delta) delta_q <= last_q - diff_q;
		if (cmd.calc_mag) begin
			mag_q <= delta_q[STAMP_W-1] ? (~delta_q + STAMP_W'(1)) : delta_q;
			neg_q <= delta_q[STAMP_W-1];
		end
	end

	// Restoring divider; the quotient bits shift into the dividend register.
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			dvd_q     <= {sum_abs[SUMMAG_W-1:0], FRAC_W'(0)};
			rem_q     <= '0;
			divisor_q <= cnt_q;
			dneg_q    <= sum_q[SUM_W-1];
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? WIN_W'(trial - {1'b0, divisor_q}) : trial[WIN_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], trial_ge};
		end
		if (cmd.out_load) mean_q <= dneg_q ? (MEAN_W'(0) - quot) : quot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q    <= 1'b0;
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.prime) primed_q <= 1'b1;
			if (cmd.accum) begin
				sum_q <= sum_q + addend;
				cnt_q <= cnt_inc;
			end else if (cmd.div_init) begin
				sum_q <= '0;
				cnt_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign mean_delta = signed'(mean_q);

endmodule

`default_nettype wire

/* hdl/timestamp_pair_error_averager.sv */
// Timestamp pair error averager.
// Input channel: in_valid/in_stall with ref_stamp and sig_stamp; a pair is
// transferred when in_valid is high and in_stall is low. The first pair after
// reset only primes the stored difference; later pairs give a delta that is
// rejected, or clipped and added to the window sum.
// Output channel: out_valid/out_stall with mean_delta, the window mean in
// signed Q.16; a transfer happens when out_valid is high and out_stall low.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Index 0 is the clip limit, 1 the reject limit, 2 the window
// length. Write only while the block is idle.
// The input is busy while a pair passes the difference and delta states, and
// the magnitude and accumulate states unless it only primes. A window-closing
// pair also passes divider setup, the 52-step restoring divider and S_OUT.
// A finished result waits in the output register while the next pair is
// taken in; if the receiver keeps stalling, the next result holds in the
// controller until the register frees up. Reset clears the sum, the count,
// the primed flag and the output valid, and restores the register defaults.
`default_nettype none

module timestamp_pair_error_averager import tspea_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [STAMP_W-1:0]      ref_stamp,
	input  wire logic [STAMP_W-1:0]      sig_stamp,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic signed [MEAN_W-1:0]     mean_delta,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DAT_W-1:0]    cfg_data
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	tspea_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	tspea_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	tspea_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ref_stamp  (ref_stamp),
		.sig_stamp  (sig_stamp),
		.cfg        (cfg),
		.cmd        (cmd),
		.status     (status),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.mean_delta (mean_delta)
	);

	// A transferred pair keeps the input busy in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not busy after a transfer");

	// Datapath commands are mutually exclusive.
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_in, cmd.calc_diff, cmd.prime, cmd.calc_delta, cmd.calc_mag,
			cmd.accum, cmd.div_init, cmd.div_step, cmd.out_load}))
		else $error("overlapping datapath commands");

	// A new result never overwrites one that the receiver is still stalling.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("result overwritten while stalled");

endmodule

`default_nettype wire

/* tb/timestamp_pair_error_averager_test.sv */
`default_nettype none

module timestamp_pair_error_averager_test;
	import tspea_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET   = 1700;
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_LIMIT   = 5000;

	// Index 3 is not a register; a write to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

	typedef enum int {STAMP_RANDOM, STAMP_ZERO, STAMP_ONES} stamp_kind_e;

	class mean_tracker;
		logic [LIM_W-1:0] clip;
		logic [LIM_W-1:0] reject;
		logic [WIN_W-1:0] window;
		bit primed;
		logic [STAMP_W-1:0] prev_diff;
		longint acc_sum;
		logic [WIN_W-1:0] acc_count;
		logic signed [MEAN_W-1:0] means_due[$];
		int errors;
		int checked;

		function new();
			clip = CLIP_RESET;
			reject = REJECT_RESET;
			window = WINDOW_RESET;
			primed = 0;
			prev_diff = '0;
			acc_sum = 0;
			acc_count = '0;
			errors = 0;
			checked = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				CFG_CLIP:   clip = data[LIM_W-1:0];
				CFG_REJECT: reject = data[LIM_W-1:0];
				CFG_WINDOW: window = data[WIN_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_pair(logic [STAMP_W-1:0] r, logic [STAMP_W-1:0] s);
			logic [STAMP_W-1:0] diff, delta, mag, sum_mag, quot;
			logic [WIN_W-1:0] win;
			longint clipped;
			diff = s - r;
			if (!primed) begin
				primed = 1;
				prev_diff = diff;
				return;
			end
			delta = prev_diff - diff;
			prev_diff = diff;
			mag = delta[STAMP_W-1] ? (~delta + 64'd1) : delta;
			if (mag >= {{(STAMP_W-LIM_W){1'b0}}, reject})
				return;
			clipped = (mag < {{(STAMP_W-LIM_W){1'b0}}, clip}) ? longint'(mag) : longint'(clip);
			if (delta[STAMP_W-1])
				clipped = -clipped;
			acc_sum += clipped;
			acc_count++;
			win = (window == '0) ? WIN_W'(1) : window;
			if (acc_count < win)
				return;
			sum_mag = (acc_sum < 0) ? -acc_sum : acc_sum;
			quot = (sum_mag << FRAC_W) / acc_count;
			if (acc_sum < 0)
				quot = ~quot + 64'd1;
			means_due.insert(means_due.size(), quot[MEAN_W-1:0]);
			acc_sum = 0;
			acc_count = '0;
		endfunction

		function void check_mean(logic signed [MEAN_W-1:0] got);
			logic signed [MEAN_W-1:0] want;
			if (means_due.size() == 0) begin
				errors++;
				$display("%0t: mean_delta expected none, got %0d", $time, got);
				return;
			end
			want = means_due.pop_front();
			checked++;
			if (got !== want) begin
				errors++;
				$display("%0t: mean_delta expected %0d, got %0d", $time, want, got);
			end
		endfunction

		function int pending();
			return means_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [STAMP_W-1:0] ref_stamp;
	logic [STAMP_W-1:0] sig_stamp;
	logic out_valid;
	logic out_stall;
	logic signed [MEAN_W-1:0] mean_delta;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	mean_tracker board;
	int send_pct = 0;
	int recv_pct = 0;
	bit hold_req = 0;
	int hold_left = 0;
	int quiet = 0;
	int items_sent = 0;
	int settings = 0;
	logic [STAMP_W-1:0] next_diff = '0;

	timestamp_pair_error_averager u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.ref_stamp(ref_stamp),
		.sig_stamp(sig_stamp),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mean_delta(mean_delta),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Values sampled at the edge are the ones from before it, so every
	// transfer is seen exactly as the block sees it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_mean(mean_delta);
			if (in_valid && !in_stall)
				board.take_pair(ref_stamp, sig_stamp);
			if (cfg_valid && cfg_ready)
				board.set_reg(cfg_index, cfg_data);
			if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
	end

	initial begin
		wait (quiet >= QUIET_LIMIT);
		$display("timestamp_pair_error_averager: mismatch");
		$finish;
	end

	// The receiver counts its own long hold-off when one is requested.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else
				out_stall <= ($urandom_range(0, 99) < recv_pct);
		end
	end

	task automatic set_idle_mix(int mix);
		case (mix)
			1: begin send_pct = 57; recv_pct = 0; end
			2: begin send_pct = 0; recv_pct = 57; end
			3: begin send_pct = 17; recv_pct = 17; end
			default: begin send_pct = 0; recv_pct = 0; end
		endcase
	endtask

	// The pair carries the requested delta relative to the previous pair.
	task automatic send_delta(logic [STAMP_W-1:0] delta, stamp_kind_e kind);
		logic [STAMP_W-1:0] r, d;
		case (kind)
			STAMP_ZERO: r = '0;
			STAMP_ONES: r = '1;
			default: r = {$urandom, $urandom};
		endcase
		d = next_diff - delta;
		next_diff = d;
		while ($urandom_range(0, 99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ref_stamp <= r;
		sig_stamp <= r + d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic write_config(logic [LIM_W-1:0] clip, logic [LIM_W-1:0] rej,
			logic [WIN_W-1:0] win);
		write_reg(CFG_CLIP, clip);
		write_reg(CFG_REJECT, rej);
		// The upper data bits of the window write are ignored by the block.
		write_reg(CFG_WINDOW, {4'($urandom), win});
		cfg_valid <= 1'b0;
		settings++;
	endtask

	function automatic logic [LIM_W-1:0] pick_limit();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 20'd1;
			2: return '1;
			3, 4: return LIM_W'($urandom);
			default: return LIM_W'($urandom_range(1, 20000));
		endcase
	endfunction

	function automatic logic [WIN_W-1:0] pick_window();
		case ($urandom_range(0, 9))
			0: return '0;
			1, 2, 3, 4, 5: return WIN_W'($urandom_range(1, 4));
			6, 7, 8: return WIN_W'($urandom_range(5, 16));
			default: return WIN_W'($urandom_range(17, 40));
		endcase
	endfunction

	// Mostly deltas up to a quarter beyond the reject limit or next to the clip and
	// reject thresholds, with some arbitrary 64-bit values, extremes and zero.
	function automatic logic [STAMP_W-1:0] pick_delta(logic [LIM_W-1:0] clip,
			logic [LIM_W-1:0] rej);
		logic [STAMP_W-1:0] mag;
		int r, top;
		r = $urandom_range(0, 99);
		top = int'(rej) + int'(rej) / 4 + 2;
		if (r < 60)
			mag = $urandom_range(0, top);
		else if (r < 70)
			mag = 64'(int'(clip) + int'($urandom_range(0, 2)) - 1);
		else if (r < 80)
			mag = 64'(int'(rej) + int'($urandom_range(0, 2)) - 1);
		else if (r < 90)
			return {$urandom, $urandom};
		else if (r < 95)
			return $urandom_range(0, 1) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		else
			return '0;
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	function automatic stamp_kind_e pick_kind();
		case ($urandom_range(0, 19))
			0: return STAMP_ZERO;
			1: return STAMP_ONES;
			default: return STAMP_RANDOM;
		endcase
	endfunction

	initial begin
		logic [LIM_W-1:0] clip, rej;
		logic [WIN_W-1:0] win;
		int phase, n;
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		ref_stamp = '0;
		sig_stamp = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CLIP;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults: the first pair primes, then thresholds on both sides.
		send_delta(64'd1, STAMP_ZERO);
		send_delta(64'd0, STAMP_ONES);
		send_delta(64'd1, STAMP_RANDOM);
		send_delta(-64'd1, STAMP_ZERO);
		send_delta(64'd999, STAMP_ONES);
		send_delta(64'd1000, STAMP_RANDOM);
		send_delta(-64'd1001, STAMP_RANDOM);
		send_delta(64'd9999, STAMP_ZERO);
		send_delta(64'd10000, STAMP_ONES);
		send_delta(-64'd9999, STAMP_RANDOM);
		send_delta(-64'd10000, STAMP_RANDOM);
		send_delta(64'h8000_0000_0000_0000, STAMP_RANDOM);
		send_delta(64'h7FFF_FFFF_FFFF_FFFF, STAMP_RANDOM);

		// Zero clip limit, then zero reject limit, then a write to no register.
		wait_idle();
		write_config('0, 20'd5, 16'd1);
		send_delta(64'd3, STAMP_RANDOM);
		send_delta(-64'd4, STAMP_RANDOM);
		wait_idle();
		write_config(20'd50, '0, 16'd1);
		send_delta(64'd0, STAMP_RANDOM);
		send_delta(64'd1, STAMP_RANDOM);
		wait_idle();
		write_reg(CFG_NONE, CFG_DAT_W'($urandom));
		cfg_valid <= 1'b0;

		// Clip at the reject limit, both at maximum, with a zero window.
		write_config('1, '1, '0);
		send_delta(64'd1048574, STAMP_RANDOM);
		send_delta(-64'd1048574, STAMP_RANDOM);
		send_delta(64'd1048575, STAMP_RANDOM);

		// Longest window, shortened below the count already summed.
		wait_idle();
		write_config(20'd1000, 20'd10000, '1);
		send_delta(64'd5, STAMP_RANDOM);
		send_delta(-64'd2, STAMP_RANDOM);
		send_delta(64'd7, STAMP_RANDOM);
		wait_idle();
		write_reg(CFG_WINDOW, 20'd2);
		cfg_valid <= 1'b0;
		send_delta(-64'd1, STAMP_RANDOM);

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			wait_idle();
			set_idle_mix(phase % 4);
			clip = pick_limit();
			rej = pick_limit();
			win = pick_window();
			if (phase == 2) begin
				// Every delta below the reject limit yields a mean, so a long receiver hold-off
				// backs up the input.
				clip = '1;
				rej = '1;
				win = 16'd1;
				set_idle_mix(0);
			end
			write_config(clip, rej, win);
			if (phase == 2)
				hold_req = 1;
			n = $urandom_range(40, 90);
			repeat (n) begin
				if ($urandom_range(0, 9) == 0)
					send_delta({$urandom, $urandom}, pick_kind());
				else
					send_delta(pick_delta(clip, rej), pick_kind());
			end
			phase++;
		end

		wait_idle();
		$display("%0d timestamp pairs sent over %0d register settings, %0d means checked",
			items_sent, settings, board.checked);
		if (board.errors == 0 && board.pending() == 0)
			$display("timestamp_pair_error_averager: match");
		else
			$display("timestamp_pair_error_averager: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
